// ===== src/tracker_pattern_unpacker_core_macros.svh =====
// assertion helpers for the unpacker core
`ifndef TRACKER_PATTERN_UNPACKER_CORE_MACROS_SVH
`define TRACKER_PATTERN_UNPACKER_CORE_MACROS_SVH

// same-cycle implication
`define TPU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tpu_pkg.sv =====
package tpu_pkg;

   // command codes on the request channel
   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_CELL    = 2'd0;
   localparam logic [1:0] KIND_ROW_END = 2'd1;
   localparam logic [1:0] KIND_PAT_END = 2'd2;

   // raw note bytes and decoded note codes
   localparam logic [7:0] RAW_RELEASE = 8'd255;
   localparam logic [7:0] RAW_OFF     = 8'd254;
   localparam logic [7:0] RAW_FADE_LO = 8'd120;
   localparam logic [6:0] NOTE_OFF     = 7'd100;
   localparam logic [6:0] NOTE_RELEASE = 7'd101;
   localparam logic [6:0] NOTE_FADE    = 7'd102;
   localparam logic [6:0] SEMITONES    = 7'd12;
   // n / 12 as (n * 43) >> 9, exact for n below 120
   localparam logic [13:0] DIV12_MUL   = 14'd43;
   localparam int          DIV12_SHIFT = 9;

   // remembered state of one channel
   typedef struct packed {
      logic [7:0] mask;
      logic [7:0] note;
      logic [7:0] ins;
      logic [7:0] vol;
      logic [7:0] fx;
      logic [7:0] fxv;
   } chan_entry_type;

   typedef struct packed {
      logic [6:0]        code;
      logic signed [4:0] octave;
   } note_type;

   // control from the parser to the channel memory
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } mem_ctl_type;

   function automatic note_type decode_note(input logic [7:0] n);
      note_type    res;
      logic [13:0] prod;
      logic [3:0]  quot;
      logic [6:0]  rem;
      prod = 14'(n[6:0]) * DIV12_MUL;
      quot = prod[DIV12_SHIFT +: 4];
      rem  = n[6:0] - 7'(quot) * SEMITONES;
      if (n == RAW_RELEASE) begin
         res.code   = NOTE_RELEASE;
         res.octave = '0;
      end else if (n == RAW_OFF) begin
         res.code   = NOTE_OFF;
         res.octave = '0;
      end else if (n >= RAW_FADE_LO) begin
         res.code   = NOTE_FADE;
         res.octave = '0;
      end else if (rem == '0) begin
         // c of the octave is written as b of the octave below
         res.code   = SEMITONES;
         res.octave = 5'(quot) - 5'sd1;
      end else begin
         res.code   = rem;
         res.octave = 5'(quot);
      end
      return res;
   endfunction

endpackage

// ===== src/tracker_pattern_unpacker_core.sv =====
// Packed pattern decoder.
// Request channel (req_valid / req_stall): one transaction per byte. With
// req_command = start, req_row_count sets the pattern length and every
// channel's remembered mask, note, instrument, volume and effect is cleared.
// With req_command = data, req_data_byte is one byte of the packed stream.
// Response channel (rsp_valid / rsp_stall): zero or one transaction per
// request: a decoded cell, a row end, or the row end that closes the pattern.
// Throughput is one byte per cycle unless the receiver stalls: each byte does a
// single read of the channel memory, issued as it is accepted, and at most one
// write back. A request reaches the response through the memory read stage,
// then the output register. A repeated channel is served from the working copy.
// Reset puts the block idle until a start command and clears the channel
// memory's valid bits in the same cycle, so no clearing pass is needed.
// When the receiver stalls, the output register holds its transaction, one
// more byte waits in the read stage, and then req_stall rises.
`include "tracker_pattern_unpacker_core_macros.svh"

module tracker_pattern_unpacker_core #(
   parameter int CHANNELS = 64,
   parameter int MAX_ROWS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [7:0]        req_data_byte,
   input  logic [8:0]        req_row_count,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [5:0]        rsp_channel,
   output logic [7:0]        rsp_row,
   output logic [3:0]        rsp_present,
   output logic [6:0]        rsp_note_code,
   output logic signed [4:0] rsp_octave,
   output logic [7:0]        rsp_instrument,
   output logic [7:0]        rsp_volume,
   output logic [7:0]        rsp_effect_cmd,
   output logic [7:0]        rsp_effect_value
);
   import tpu_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [2:0] {
      PH_CHAN, PH_MASK, PH_NOTE, PH_INS, PH_VOL, PH_FX, PH_FXV
   } phase_type;

   // next byte position given the mask and the field just taken
   function automatic phase_type next_field(input logic [7:0] m, input phase_type from);
      phase_type res;
      if (from < PH_NOTE && m[0]) begin
         res = PH_NOTE;
      end else if (from < PH_INS && m[1]) begin
         res = PH_INS;
      end else if (from < PH_VOL && m[2]) begin
         res = PH_VOL;
      end else if (from < PH_FX && m[3]) begin
         res = PH_FX;
      end else begin
         res = PH_CHAN;
      end
      return res;
   endfunction

   // channel number modulo CHANNELS, restoring remainder over six bits
   function automatic logic [CH_W-1:0] chan_mod(input logic [5:0] v);
      logic [6:0] r;
      r = '0;
      for (int i = 5; i >= 0; i--) begin
         r = {r[5:0], v[i]};
         if (r >= 7'(CHANNELS)) begin
            r = r - 7'(CHANNELS);
         end
      end
      return r[CH_W-1:0];
   endfunction

   // parser state
   phase_type        phase_ff, phase_in;
   logic [CH_W-1:0]  chan_ff, chan_in;
   chan_entry_type   entry_ff, entry_in;
   logic [8:0]       row_counter_ff, row_counter_in;
   logic [8:0]       rows_ff, rows_in;
   logic             done_ff, done_in;

   // read stage
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_cmd_ff, s1_cmd_in;
   logic [7:0]       s1_byte_ff, s1_byte_in;
   logic [8:0]       s1_rows_ff, s1_rows_in;
   logic [CH_W-1:0]  s1_chan_ff, s1_chan_in;

   // output register
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_kind_ff, out_kind_in;
   logic [5:0]       out_channel_ff, out_channel_in;
   logic [7:0]       out_row_ff, out_row_in;
   logic [3:0]       out_present_ff, out_present_in;
   logic [6:0]       out_note_ff, out_note_in;
   logic signed [4:0] out_octave_ff, out_octave_in;
   logic [7:0]       out_ins_ff, out_ins_in;
   logic [7:0]       out_vol_ff, out_vol_in;
   logic [7:0]       out_fx_ff, out_fx_in;
   logic [7:0]       out_fxv_ff, out_fxv_in;

   logic             accept;
   logic             s1_go;
   logic             s1_fire;
   logic             emit;
   logic [1:0]       emit_kind;
   logic [8:0]       row_inc;
   logic [3:0]       pres;
   note_type         note_dec;
   chan_entry_type   fetched;
   chan_entry_type   mem_rd_data;
   mem_ctl_type      mem_ctl;

   // handshake: the read stage moves when the output register is free
   assign s1_go     = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;
   assign s1_fire   = s1_valid_ff && s1_go;

   // channel memory, read as a byte is accepted
   tpu_chan_mem #(
      .CHANNELS (CHANNELS)
   ) u_chan_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (chan_mod(req_data_byte[5:0])),
      .wr_addr (chan_ff),
      .wr_data (entry_in),
      .rd_data (mem_rd_data)
   );

   // latest write always targets the current channel, so forward it
   assign fetched = (s1_chan_ff == chan_ff) ? entry_ff : mem_rd_data;

   // read stage capture
   always_comb begin
      s1_cmd_in  = s1_cmd_ff;
      s1_byte_in = s1_byte_ff;
      s1_rows_in = s1_rows_ff;
      s1_chan_in = s1_chan_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_cmd_in   = req_command;
         s1_byte_in  = req_data_byte;
         s1_rows_in  = req_row_count;
         s1_chan_in  = chan_mod(req_data_byte[5:0]);
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // byte parser: read, modify, write back the current channel entry
   always_comb begin
      phase_in       = phase_ff;
      chan_in        = chan_ff;
      entry_in       = entry_ff;
      row_counter_in = row_counter_ff;
      rows_in        = rows_ff;
      done_in        = done_ff;
      emit           = 1'b0;
      emit_kind      = KIND_CELL;
      row_inc        = row_counter_ff + 9'd1;
      mem_ctl        = '0;
      mem_ctl.rd_en  = accept;
      if (s1_fire) begin
         if (s1_cmd_ff == CMD_START) begin
            rows_in        = (s1_rows_ff > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : s1_rows_ff;
            row_counter_in = '0;
            done_in        = 1'b0;
            phase_in       = PH_CHAN;
            chan_in        = '0;
            entry_in       = '0;
            mem_ctl.clear  = 1'b1;
         end else if (!done_ff) begin
            unique case (phase_ff)
               PH_MASK: begin
                  entry_in.mask = s1_byte_ff;
                  mem_ctl.wr_en = 1'b1;
                  phase_in      = next_field(s1_byte_ff, PH_MASK);
                  emit          = (phase_in == PH_CHAN);
               end
               PH_NOTE: begin
                  entry_in.note = s1_byte_ff;
                  mem_ctl.wr_en = 1'b1;
                  phase_in      = next_field(entry_ff.mask, PH_NOTE);
                  emit          = (phase_in == PH_CHAN);
               end
               PH_INS: begin
                  entry_in.ins  = s1_byte_ff;
                  mem_ctl.wr_en = 1'b1;
                  phase_in      = next_field(entry_ff.mask, PH_INS);
                  emit          = (phase_in == PH_CHAN);
               end
               PH_VOL: begin
                  entry_in.vol  = s1_byte_ff;
                  mem_ctl.wr_en = 1'b1;
                  phase_in      = next_field(entry_ff.mask, PH_VOL);
                  emit          = (phase_in == PH_CHAN);
               end
               PH_FX: begin
                  entry_in.fx   = s1_byte_ff;
                  mem_ctl.wr_en = 1'b1;
                  phase_in      = PH_FXV;
               end
               PH_FXV: begin
                  entry_in.fxv  = s1_byte_ff;
                  mem_ctl.wr_en = 1'b1;
                  phase_in      = PH_CHAN;
                  emit          = 1'b1;
               end
               default: begin
                  // channel byte position, also for the unused phase code
                  phase_in = PH_CHAN;
                  if (s1_byte_ff == 8'd0) begin
                     emit           = 1'b1;
                     row_counter_in = row_inc;
                     if (row_inc >= rows_ff) begin
                        done_in   = 1'b1;
                        emit_kind = KIND_PAT_END;
                     end else begin
                        emit_kind = KIND_ROW_END;
                     end
                  end else begin
                     chan_in  = s1_chan_ff;
                     entry_in = fetched;
                     if (s1_byte_ff[7]) begin
                        phase_in = PH_MASK;
                     end else begin
                        phase_in = next_field(fetched.mask, PH_MASK);
                        emit     = (phase_in == PH_CHAN);
                     end
                  end
               end
            endcase
         end
      end
   end

   // cell formatting from the updated entry
   assign pres     = entry_in.mask[3:0] | entry_in.mask[7:4];
   assign note_dec = decode_note(entry_in.note);

   // output register load
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_kind_in    = out_kind_ff;
      out_channel_in = out_channel_ff;
      out_row_in     = out_row_ff;
      out_present_in = out_present_ff;
      out_note_in    = out_note_ff;
      out_octave_in  = out_octave_ff;
      out_ins_in     = out_ins_ff;
      out_vol_in     = out_vol_ff;
      out_fx_in      = out_fx_ff;
      out_fxv_in     = out_fxv_ff;
      if (s1_go) begin
         out_valid_in = s1_fire && emit;
      end
      if (s1_fire && emit) begin
         out_kind_in    = emit_kind;
         out_row_in     = row_counter_ff[7:0];
         out_channel_in = '0;
         out_present_in = '0;
         out_note_in    = '0;
         out_octave_in  = '0;
         out_ins_in     = '0;
         out_vol_in     = '0;
         out_fx_in      = '0;
         out_fxv_in     = '0;
         if (emit_kind == KIND_CELL) begin
            out_channel_in = 6'(chan_in);
            out_present_in = pres;
            if (pres[0]) begin
               out_note_in   = note_dec.code;
               out_octave_in = note_dec.octave;
            end
            if (pres[1]) begin
               out_ins_in = entry_in.ins - 8'd1;
            end
            if (pres[2]) begin
               out_vol_in = entry_in.vol;
            end
            if (pres[3]) begin
               out_fx_in  = entry_in.fx;
               out_fxv_in = entry_in.fxv;
            end
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_CHAN;
         chan_ff        <= '0;
         entry_ff       <= '0;
         row_counter_ff <= '0;
         rows_ff        <= '0;
         done_ff        <= 1'b1;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         chan_ff        <= chan_in;
         entry_ff       <= entry_in;
         row_counter_ff <= row_counter_in;
         rows_ff        <= rows_in;
         done_ff        <= done_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
      s1_cmd_ff      <= s1_cmd_in;
      s1_byte_ff     <= s1_byte_in;
      s1_rows_ff     <= s1_rows_in;
      s1_chan_ff     <= s1_chan_in;
      out_kind_ff    <= out_kind_in;
      out_channel_ff <= out_channel_in;
      out_row_ff     <= out_row_in;
      out_present_ff <= out_present_in;
      out_note_ff    <= out_note_in;
      out_octave_ff  <= out_octave_in;
      out_ins_ff     <= out_ins_in;
      out_vol_ff     <= out_vol_in;
      out_fx_ff      <= out_fx_in;
      out_fxv_ff     <= out_fxv_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_channel      = out_channel_ff;
   assign rsp_row          = out_row_ff;
   assign rsp_present      = out_present_ff;
   assign rsp_note_code    = out_note_ff;
   assign rsp_octave       = out_octave_ff;
   assign rsp_instrument   = out_ins_ff;
   assign rsp_volume       = out_vol_ff;
   assign rsp_effect_cmd   = out_fx_ff;
   assign rsp_effect_value = out_fxv_ff;

   // checks
   `TPU_ASSERT_IMP(a_row_end_clean, clock, reset, rsp_valid && (rsp_kind != KIND_CELL), (rsp_channel == '0) && (rsp_present == '0), "row end transaction carries cell data")
   `TPU_ASSERT_NEXT(a_start_arms, clock, reset, s1_fire && (s1_cmd_ff == CMD_START), !done_ff && (phase_ff == PH_CHAN) && (row_counter_ff == '0), "start did not arm the parser")
   `TPU_ASSERT_NEXT(a_end_idles, clock, reset, s1_fire && emit && (emit_kind == KIND_PAT_END), done_ff, "pattern end did not idle the parser")
   `TPU_ASSERT_NEXT(a_stage_held, clock, reset, s1_valid_ff && !s1_go, s1_valid_ff, "read stage transaction dropped")
   `TPU_ASSERT_IMP(a_idle_quiet, clock, reset, s1_fire && done_ff && (s1_cmd_ff == CMD_DATA), !emit && !mem_ctl.wr_en, "idle parser produced output")

endmodule

// ===== src/tpu_chan_mem.sv =====
module tpu_chan_mem #(
   parameter int CHANNELS = 64,
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tpu_pkg::mem_ctl_type    ctl,
   input  logic [CH_W-1:0]         rd_addr,
   input  logic [CH_W-1:0]         wr_addr,
   input  tpu_pkg::chan_entry_type wr_data,
   output tpu_pkg::chan_entry_type rd_data
);
   import tpu_pkg::*;

   chan_entry_type              store_ff [CHANNELS];
   chan_entry_type              rd_q_ff;
   logic [CH_W-1:0]             rd_addr_ff;
   logic [CHANNELS-1:0]         valid_ff;

   // storage array with registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff    <= store_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // per-entry valid bits, cleared at once by reset or pattern start
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // entries not written since the last clear read as zero
   assign rd_data = valid_ff[rd_addr_ff] ? rd_q_ff : '0;

endmodule
